// ===== rtl/dlc_pkg.sv =====
// Shared types and constants for the 3D distance limit clamp.
// No dependencies; used by every module under rtl/.
package dlc_pkg;

	localparam int COORD_FRAC_BITS = 16;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int D2_W    = 66;
	localparam int ROOT_W  = 33;
	localparam int NUM_W   = 64;
	localparam int QUO_W   = 32;
	localparam int LIM_W   = 31;
	localparam int INFL_W  = 17;

	localparam logic [INFL_W-1:0] INFL_ONE = 17'd65536;

	// below this squared length the direction falls back to +z
	localparam logic [D2_W-1:0] SMALL_D2 =
		((66'd1 << (2 * COORD_FRAC_BITS)) + 66'd99999999) / 66'd100000000;

	typedef enum logic [1:0] {
		REG_LIMIT  = 2'd0,
		REG_REGION = 2'd1,
		REG_INFL   = 2'd2
	} reg_idx_t;

	// item context carried alongside the root and divide pipelines
	typedef struct packed {
		logic [2:0][COORD_W-1:0] dvn;
		logic [2:0][DIFF_W-1:0]  d;
		logic                    apply;
		logic                    near_zero;
	} item_sb_t;

endpackage

// ===== rtl/dlc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on dlc_pkg.
module dlc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [dlc_pkg::D2_W-1:0]    in_rad,
	input  dlc_pkg::item_sb_t           in_sb,
	output logic                        out_vld,
	output logic [dlc_pkg::ROOT_W-1:0]  out_root,
	output dlc_pkg::item_sb_t           out_sb
);

	localparam int NS = dlc_pkg::ROOT_W;
	localparam int RW = dlc_pkg::D2_W + 1;

	logic [RW-1:0]                  rem_s  [0:NS];
	logic [dlc_pkg::ROOT_W-1:0]     root_s [0:NS];
	dlc_pkg::item_sb_t              sb_s   [0:NS];
	logic                           vld_s  [0:NS];

	assign rem_s[0]  = {1'b0, in_rad};
	assign root_s[0] = '0;
	assign sb_s[0]   = in_sb;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int B = NS - 1 - k;
		logic [RW-1:0] trial;
		logic          take;

		always_comb begin
			trial = ({{(RW - dlc_pkg::ROOT_W){1'b0}}, root_s[k]} << (B + 1))
				| ({{(RW - 1){1'b0}}, 1'b1} << (2 * B));
			take = trial <= rem_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
			root_s[k+1] <= take ? (root_s[k] | (33'd1 << B)) : root_s[k];
			sb_s[k+1]   <= sb_s[k];
		end
	end

	assign out_vld  = vld_s[NS];
	assign out_root = root_s[NS];
	assign out_sb   = sb_s[NS];

endmodule

// ===== rtl/dlc_div.sv =====
// Pipelined three-lane rounding divider sharing one divisor, one bit per stage.
// Depends on dlc_pkg.
module dlc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	input  logic [2:0][dlc_pkg::NUM_W-1:0]        in_num,
	input  logic [dlc_pkg::ROOT_W-1:0]            in_den,
	input  dlc_pkg::item_sb_t                     in_sb,
	output logic                                  out_vld,
	output logic [2:0][dlc_pkg::QUO_W-1:0]        out_quo,
	output dlc_pkg::item_sb_t                     out_sb
);

	localparam int NS = dlc_pkg::QUO_W;
	localparam int SW = dlc_pkg::NUM_W + 1;

	logic [2:0][dlc_pkg::NUM_W-1:0]  rem_s [0:NS];
	logic [2:0][dlc_pkg::QUO_W-1:0]  quo_s [0:NS];
	logic [dlc_pkg::ROOT_W-1:0]      den_s [0:NS];
	dlc_pkg::item_sb_t               sb_s  [0:NS];
	logic                            vld_s [0:NS];

	// add half the divisor for round to nearest
	for (genvar j = 0; j < 3; j++) begin : g_init
		assign rem_s[0][j] = in_num[j]
			+ {{(dlc_pkg::NUM_W - dlc_pkg::ROOT_W){1'b0}}, in_den >> 1};
	end
	assign quo_s[0] = '0;
	assign den_s[0] = in_den;
	assign sb_s[0]  = in_sb;
	assign vld_s[0] = in_vld;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int B = NS - 1 - k;
		logic [SW-1:0] sh;

		assign sh = {{(SW - dlc_pkg::ROOT_W){1'b0}}, den_s[k]} << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic take;
			assign take = {1'b0, rem_s[k][j]} >= sh;

			always_ff @(posedge clk) begin
				rem_s[k+1][j] <= take ? rem_s[k][j] - sh[dlc_pkg::NUM_W-1:0] : rem_s[k][j];
				quo_s[k+1][j] <= take ? (quo_s[k][j] | (32'd1 << B)) : quo_s[k][j];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			sb_s[k+1]  <= sb_s[k];
		end
	end

	assign out_vld = vld_s[NS];
	assign out_quo = quo_s[NS];
	assign out_sb  = sb_s[NS];

endmodule

// ===== rtl/distance_limit_clamp_3d_top.sv =====
// Top level of the 3D distance limit clamp: register port, front and back stages.
// Depends on dlc_pkg, dlc_sqrt and dlc_div.
//
// One word enters per clock (busy is always low) and its result passes through
// 72 register stages: done rises with new_x, new_y, new_z and moved, which
// are taken at the next edge. The stages are 3 front stages for difference,
// squares and compare, 33 stages of the bit-per-stage square root, 1 multiply stage,
// 32 stages of the bit-per-stage divider and 3 stages of blend, round and saturate.
// The receiver cannot stall; results are presented for one clock only. Registers
// must be written only while no word is in flight.
module distance_limit_clamp_3d_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] driver_x,
	input  logic signed [31:0] driver_y,
	input  logic signed [31:0] driver_z,
	input  logic signed [31:0] driven_x,
	input  logic signed [31:0] driven_y,
	input  logic signed [31:0] driven_z,
	output logic               done,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_z,
	output logic               moved,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [dlc_pkg::LIM_W-1:0]  limit_q;
	logic                       region_q;
	logic [dlc_pkg::INFL_W-1:0] infl_q;
	logic [dlc_pkg::INFL_W-1:0] infl_eff;
	dlc_pkg::reg_idx_t          widx;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign widx   = dlc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= '0;
			region_q <= 1'b0;
			infl_q   <= dlc_pkg::INFL_ONE;
		end else if (psel && penable && pwrite) begin
			unique case (widx)
				dlc_pkg::REG_LIMIT:  limit_q  <= pwdata[dlc_pkg::LIM_W-1:0];
				dlc_pkg::REG_REGION: region_q <= pwdata[0];
				dlc_pkg::REG_INFL:   infl_q   <= pwdata[dlc_pkg::INFL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			dlc_pkg::REG_LIMIT:  prdata = {1'b0, limit_q};
			dlc_pkg::REG_REGION: prdata = {31'd0, region_q};
			dlc_pkg::REG_INFL:   prdata = {15'd0, infl_q};
			default:             prdata = '0;
		endcase
	end

	assign infl_eff = (infl_q > dlc_pkg::INFL_ONE) ? dlc_pkg::INFL_ONE : infl_q;

	// front end
	logic [2:0][31:0] drv_in, dvn_in;
	assign drv_in = {driver_z, driver_y, driver_x};
	assign dvn_in = {driven_z, driven_y, driven_x};

	logic                    vld_s1, vld_s2, vld_s3;
	logic [2:0][31:0]        dvn_s1, dvn_s2;
	logic [2:0][32:0]        d_s1, d_s2;
	logic [2:0][63:0]        sq_s2;
	logic [61:0]             lim2_s2;
	logic [65:0]             d2_s3;
	dlc_pkg::item_sb_t       sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	logic [2:0][31:0] mag_s1;
	logic [65:0]      d2_sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] = d_s1[i][32] ? 32'(-d_s1[i]) : d_s1[i][31:0];
		end
		d2_sum = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dvn_s1[i] <= dvn_in[i];
			d_s1[i]   <= {dvn_in[i][31], dvn_in[i]} - {drv_in[i][31], drv_in[i]};
			sq_s2[i]  <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
		end
		dvn_s2  <= dvn_s1;
		d_s2    <= d_s1;
		lim2_s2 <= 62'(limit_q) * 62'(limit_q);
		d2_s3        <= d2_sum;
		sb_s3.dvn    <= dvn_s2;
		sb_s3.d      <= d_s2;
		sb_s3.apply  <= (infl_eff != '0)
			&& (region_q ? (d2_sum < 66'(lim2_s2)) : (d2_sum > 66'(lim2_s2)));
		sb_s3.near_zero <= d2_sum < dlc_pkg::SMALL_D2;
	end

	// square root
	logic              vld_r;
	logic [32:0]       len_r;
	dlc_pkg::item_sb_t sb_r;

	dlc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_rad   (d2_s3),
		.in_sb    (sb_s3),
		.out_vld  (vld_r),
		.out_root (len_r),
		.out_sb   (sb_r)
	);

	// numerators for the divider
	logic              vld_s4;
	logic [2:0][63:0]  num_s4;
	logic [32:0]       den_s4;
	dlc_pkg::item_sb_t sb_s4;
	logic [2:0][31:0]  mag_r;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_r[i] = sb_r.d[i][32] ? 32'(-sb_r.d[i]) : sb_r.d[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s4[i] <= 64'(mag_r[i]) * 64'(limit_q);
		end
		den_s4 <= (len_r == '0) ? 33'd1 : len_r;
		sb_s4  <= sb_r;
	end

	// divider
	logic              vld_q;
	logic [2:0][31:0]  quo_q;
	dlc_pkg::item_sb_t sb_q;

	dlc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.in_num  (num_s4),
		.in_den  (den_s4),
		.in_sb   (sb_s4),
		.out_vld (vld_q),
		.out_quo (quo_q),
		.out_sb  (sb_q)
	);

	// blend
	logic              vld_s5, vld_s6;
	logic [2:0][34:0]  delta_s5;
	logic [2:0][50:0]  prod_s6;
	logic [2:0]        neg_s6;
	dlc_pkg::item_sb_t sb_s5, sb_s6;
	logic [2:0][34:0]  off_q, delta_n;
	logic [2:0][33:0]  dmag_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (sb_q.near_zero) begin
				off_q[i] = (i == 2) ? 35'(limit_q) : '0;
			end else begin
				off_q[i] = sb_q.d[i][32] ? -35'(quo_q[i]) : 35'(quo_q[i]);
			end
			delta_n[i] = off_q[i] - {{2{sb_q.d[i][32]}}, sb_q.d[i]};
			dmag_s5[i] = delta_s5[i][34] ? 34'(-delta_s5[i]) : delta_s5[i][33:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s5 <= vld_q;
			vld_s6 <= vld_s5;
			done   <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		delta_s5 <= delta_n;
		sb_s5    <= sb_q;
		for (int i = 0; i < 3; i++) begin
			prod_s6[i] <= 51'(dmag_s5[i]) * 51'(infl_eff);
			neg_s6[i]  <= delta_s5[i][34];
		end
		sb_s6 <= sb_s5;
	end

	logic [2:0][35:0] step_mag;
	logic [2:0][36:0] sum_n;
	logic [2:0][31:0] res_n;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			step_mag[i] = 36'((52'(prod_s6[i]) + 52'd32768) >> 16);
			sum_n[i] = {{5{sb_s6.dvn[i][31]}}, sb_s6.dvn[i]}
				+ (neg_s6[i] ? -{1'b0, step_mag[i]} : {1'b0, step_mag[i]});
			if (!sb_s6.apply) begin
				res_n[i] = sb_s6.dvn[i];
			end else if (!sum_n[i][36] && (sum_n[i][35:31] != '0)) begin
				res_n[i] = 32'h7FFF_FFFF;
			end else if (sum_n[i][36] && (sum_n[i][35:31] != '1)) begin
				res_n[i] = 32'h8000_0000;
			end else begin
				res_n[i] = sum_n[i][31:0];
			end
		end
	end

	logic [2:0][31:0] res_q;
	logic             moved_q;

	always_ff @(posedge clk) begin
		res_q   <= res_n;
		moved_q <= sb_s6.apply;
	end

	assign new_x = res_q[0];
	assign new_y = res_q[1];
	assign new_z = res_q[2];
	assign moved = moved_q;

endmodule
